### hdl/rls_pkg.sv
`timescale 1ns / 1ps
package rls_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int W = 48;
	localparam logic [16:0] LAMBDA_RESET = 17'd64880;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_PPHI, OP_PHIP, OP_S, OP_ACC, OP_DEN, OP_GAIN,
		OP_THETA, OP_DOWN, OP_COV, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] r;
		logic [1:0] c;
		logic       first;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic mac_busy;
		logic div_busy;
	} sts_t;

	function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] x);
		if (x > $signed({{2{WMAX[W-1]}}, WMAX})) return WMAX;
		if (x < $signed({{2{WMIN[W-1]}}, WMIN})) return WMIN;
		return x[W-1:0];
	endfunction
endpackage

### hdl/rls_estimator_4param.sv
`timescale 1ns / 1ps
// Four-parameter recursive least squares estimator, signed fixed point.
// Input channel s_axis_*: one regressor row and residual per item.
// Output channel m_axis_*: the four updated parameters, one item per input.
// forgetting_factor_we/_wdata write lambda (unsigned Q1.16); write only idle.
// Each item runs 60 multiplies on one shared multiply unit, 20 divisions
// on one restoring divider and control steps, strictly in sequence, from
// acceptance to m_axis_tvalid. No new item is taken until the last is
// through; s_axis_tready is low while an item is being processed.
// The accepted item is held in an input register. The result sits in an
// output register; the next item is accepted while it waits, but the new
// result is held back, and the input stalls, until the old one is taken.
// Reset sets the covariance to 1000 on the diagonal, parameters to zero and
// lambda to 64880/65536.
module rls_estimator_4param import rls_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// regressor_mass, regressor_cx, regressor_cy, regressor_cz, residual
	input  logic [159:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// est_mass (31b + 1 pad), est_mass_cx, est_mass_cy, est_mass_cz
	output logic [127:0] m_axis_tdata,
	input  logic         forgetting_factor_we,
	input  logic [16:0]  forgetting_factor_wdata
);
	logic [16:0]  lambda_q;
	logic         busy, out_load, in_fire;
	cmd_t         cmd;
	sts_t         sts;
	logic [127:0] dp_out;
	logic [159:0] in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lambda_q <= LAMBDA_RESET;
		else if (forgetting_factor_we) lambda_q <= forgetting_factor_wdata;
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// hold the accepted item for the load step
	always_ff @(posedge clk) begin
		if (in_fire) in_q <= s_axis_tdata;
	end

	rls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_free(!m_axis_tvalid || m_axis_tready), .sts(sts),
		.busy(busy), .out_load(out_load), .cmd(cmd)
	);

	rls_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_data(in_q),
		.lambda(lambda_q), .sts(sts), .out_data(dp_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) m_axis_tdata <= {dp_out[127:32], 1'b0, dp_out[30:0]};
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("accepted while busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_axis_tvalid || $past(m_axis_tready) || !$past(m_axis_tvalid)))
		else $error("result overwritten");
	a_mass_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[31]) else $error("mass pad bit set");
endmodule

### hdl/rls_div.sv
`timescale 1ns / 1ps
// Restoring divider: q = sat((num << FRAC) / den), truncated toward zero, den > 0.
module rls_div import rls_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic                busy,
	output logic                done,
	output logic signed [W-1:0] quo
);
	localparam int NB = W + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	logic [NB-1:0] dvd_q, q_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  dvs_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic [W-1:0]  mag;

	assign mag   = num[W-1] ? W'(-num) : W'(num);
	assign trial = {rem_q[W-1:0], dvd_q[NB-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= CW'(NB);
				dvd_q <= {mag, {FRAC_BITS{1'b0}}};
				dvs_q <= den;
				neg_q <= num[W-1];
				rem_q <= '0;
				q_q   <= '0;
			end else if (busy) begin
				dvd_q <= {dvd_q[NB-2:0], 1'b0};
				if (!diff[W]) begin
					rem_q <= diff;
					q_q   <= {q_q[NB-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					q_q   <= {q_q[NB-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		logic ovf;
		logic [NB-1:0] hi;
		hi  = q_q >> (W - 1);
		ovf = (hi != '0);
		if (ovf) quo = neg_q ? WMIN : WMAX;
		else if (neg_q) quo = -$signed(q_q[W-1:0]);
		else quo = q_q[W-1:0];
	end
endmodule

### hdl/rls_datapath.sv
`timescale 1ns / 1ps
// Shared multiply unit (multicycle, 48x48 split in 24-bit partials), accumulator,
// covariance and parameter storage, plus one divider.
module rls_datapath import rls_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  logic [159:0] in_data,
	input  logic [16:0]  lambda,
	output sts_t         sts,
	output logic [127:0] out_data
);
	localparam int PW = 2 * W;
	localparam int LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	logic signed [W-1:0] cov_q [16];
	logic signed [W-1:0] newp_q [16];
	logic signed [31:0]  theta_q [4];
	logic signed [W-1:0] phi_q [4];
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] pphi_q [4];
	logic signed [W-1:0] phip_q [4];
	logic signed [W-1:0] gain_q [4];
	logic signed [W-1:0] s_q, acc_q, den_q, innov_q, lamd_q;
	logic signed [W-1:0] lam;
	logic signed [W+1:0] sum_q;

	// multiplier: operands latched, four 24x24 partials, one per cycle,
	// then the product is rounded and saturated into mres_q
	logic signed [W-1:0] ma, mb;
	logic [W-1:0] mam_q, mbm_q;
	logic         mneg_q;
	logic [2:0]   mph_q;
	logic [PW-1:0] mprod_q;
	logic          mbusy_q, mdone_q;
	logic [1:0]    mr_q, mc_q;
	op_t           mop_q;
	logic          mfirst_q, mlast_q;
	logic [23:0]   pa, pb;
	logic [47:0]   pp;
	logic signed [W-1:0] mres;
	logic signed [W-1:0] mres_q;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_PPHI:  begin ma = cov_q[{cmd.r, cmd.c}]; mb = phi_q[cmd.c]; end
			OP_PHIP:  begin ma = phi_q[cmd.c]; mb = cov_q[{cmd.c, cmd.r}]; end
			OP_S:     begin ma = phi_q[cmd.r]; mb = pphi_q[cmd.r]; end
			OP_ACC:   begin ma = phi_q[cmd.r]; mb = W'(theta_q[cmd.r]); end
			OP_THETA: begin ma = gain_q[cmd.r]; mb = innov_q; end
			OP_DOWN:  begin ma = gain_q[cmd.r]; mb = phip_q[cmd.c]; end
			default:  ;
		endcase
	end

	assign pa = mph_q[0] ? mam_q[47:24] : mam_q[23:0];
	assign pb = mph_q[1] ? mbm_q[47:24] : mbm_q[23:0];
	assign pp = pa * pb;

	logic mstart;
	assign mstart = (cmd.op == OP_PPHI) || (cmd.op == OP_PHIP) || (cmd.op == OP_S) ||
		(cmd.op == OP_ACC) || (cmd.op == OP_THETA) || (cmd.op == OP_DOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mph_q   <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (mstart) begin
				mbusy_q  <= 1'b1;
				mph_q    <= '0;
				mam_q    <= ma[W-1] ? W'(-ma) : W'(ma);
				mbm_q    <= mb[W-1] ? W'(-mb) : W'(mb);
				mneg_q   <= ma[W-1] ^ mb[W-1];
				mprod_q  <= '0;
				mop_q    <= cmd.op;
				mr_q     <= cmd.r;
				mc_q     <= cmd.c;
				mfirst_q <= cmd.first;
				mlast_q  <= cmd.last;
			end else if (mbusy_q) begin
				mph_q <= mph_q + 3'd1;
				if (mph_q == 3'd4) begin
					mres_q  <= mres;
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end else begin
					mprod_q <= mprod_q + (PW'(pp) << (24 * (int'(mph_q[0]) + int'(mph_q[1]))));
				end
			end
		end
	end

	// floor shift and saturate the finished product
	always_comb begin
		logic [PW-1:0] sh;
		logic [PW-1:0] hi;
		logic          fr;
		logic [PW:0]   m;
		sh = mprod_q >> FRAC_BITS;
		fr = (mprod_q & ((PW'(1) << FRAC_BITS) - 1'b1)) != '0;
		m  = {1'b0, sh} + ((mneg_q && fr) ? 1'b1 : 1'b0);
		hi = m[PW-1:0] >> (W - 1);
		if (m[PW] || hi > 1 || (hi == 1 && m[W-2:0] != '0) ||
			(hi == 1 && !mneg_q))
			mres = mneg_q ? WMIN : WMAX;
		else if (mneg_q) mres = -$signed(m[W-1:0]);
		else mres = m[W-1:0];
	end

	// divider
	logic dstart, dbusy, ddone;
	logic signed [W-1:0] dnum, dden, dquo;
	logic [1:0] dr_q, dc_q;
	logic       dcov_q;
	assign dstart = (cmd.op == OP_GAIN) || (cmd.op == OP_COV);
	always_comb begin
		if (cmd.op == OP_GAIN) begin
			dnum = pphi_q[cmd.r];
			dden = den_q;
		end else begin
			dnum = newp_q[{cmd.r, cmd.c}];
			dden = lamd_q;
		end
	end

	rls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .done(ddone), .quo(dquo)
	);

	assign sts.mac_busy = mbusy_q | mstart;
	assign sts.div_busy = dbusy | dstart;

	logic signed [W+1:0] nsum;
	assign nsum = (mfirst_q ? '0 : sum_q) + (W+2)'(mres_q);

	// rescale lambda to FRAC_BITS fractional bits
	assign lam = (W'(lambda) << LSH) >> RSH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				cov_q[i] <= (i % 5 == 0) ? (W'(1000) << FRAC_BITS) : '0;
			for (int i = 0; i < 4; i++) theta_q[i] <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					for (int i = 0; i < 4; i++)
						phi_q[i] <= W'($signed(in_data[32*i +: 32]));
					y_q    <= W'($signed(in_data[159:128]));
					lamd_q <= (lam < 1) ? W'(1) : lam;
				end
				OP_DEN: begin
					logic signed [W-1:0] d;
					d = sat_w((W+2)'(lam) + (W+2)'(s_q));
					den_q   <= (d < 1) ? W'(1) : d;
					innov_q <= sat_w((W+2)'(y_q) - (W+2)'(acc_q));
				end
				OP_OUT: begin
					for (int i = 0; i < 16; i++) cov_q[i] <= newp_q[i];
					if (theta_q[0] < 0) theta_q[0] <= '0;
				end
				default: ;
			endcase
			if (mdone_q) begin
				sum_q <= nsum;
				if (mlast_q) begin
					case (mop_q)
						OP_PPHI: pphi_q[mr_q] <= sat_w(nsum);
						OP_PHIP: phip_q[mr_q] <= sat_w(nsum);
						OP_S:    s_q <= sat_w(nsum);
						OP_ACC:  acc_q <= sat_w(nsum);
						default: ;
					endcase
				end
				if (mop_q == OP_THETA) begin
					logic signed [W+1:0] t;
					t = (W+2)'(theta_q[mr_q]) + (W+2)'(mres_q);
					// drop a parameter that leaves the 32-bit range
					theta_q[mr_q] <= (t[W+1:31] != '0 && t[W+1:31] != '1) ? '0 : t[31:0];
				end
				if (mop_q == OP_DOWN)
					newp_q[{mr_q, mc_q}] <= sat_w((W+2)'(cov_q[{mr_q, mc_q}]) -
						(W+2)'(mres_q));
			end
			if (dstart) begin
				dr_q   <= cmd.r;
				dc_q   <= cmd.c;
				dcov_q <= (cmd.op == OP_COV);
			end
			if (ddone) begin
				if (dcov_q) newp_q[{dr_q, dc_q}] <= dquo;
				else gain_q[dr_q] <= dquo;
			end
		end
	end

	assign out_data = {theta_q[3], theta_q[2], theta_q[1], theta_q[0]};
endmodule

### hdl/rls_ctrl.sv
`timescale 1ns / 1ps
module rls_ctrl import rls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  sts_t sts,
	output logic busy,
	output logic out_load,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_PPHI, S_PHIP, S_S, S_ACC, S_DEN, S_GAIN, S_THETA, S_DOWN, S_COV,
		S_DRAIN, S_OUT
	} state_t;
	state_t st_q;
	logic [1:0] r_q, c_q;
	logic       wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			r_q <= '0;
			c_q <= '0;
			wait_q <= 1'b0;
			busy <= 1'b0;
			out_load <= 1'b0;
			cmd <= '0;
		end else begin
			cmd.op <= OP_NONE;
			out_load <= 1'b0;
			case (st_q)
				S_IDLE: if (in_fire) begin
					cmd.op <= OP_LOAD;
					busy <= 1'b1;
					r_q <= '0;
					c_q <= '0;
					wait_q <= 1'b0;
					st_q <= S_PPHI;
				end
				S_PPHI, S_PHIP, S_S, S_ACC, S_THETA, S_DOWN: begin
					// issue one multiply, then wait for the unit to free up
					if (!wait_q) begin
						wait_q <= 1'b1;
						cmd.r <= r_q;
						cmd.c <= c_q;
						case (st_q)
							S_PPHI: begin
								cmd.op <= OP_PPHI; cmd.first <= c_q == 0; cmd.last <= c_q == 3;
							end
							S_PHIP: begin
								cmd.op <= OP_PHIP; cmd.first <= c_q == 0; cmd.last <= c_q == 3;
							end
							S_S: begin
								cmd.op <= OP_S; cmd.first <= r_q == 0; cmd.last <= r_q == 3;
							end
							S_ACC: begin
								cmd.op <= OP_ACC; cmd.first <= r_q == 0; cmd.last <= r_q == 3;
							end
							S_THETA: begin
								cmd.op <= OP_THETA; cmd.first <= 1'b1; cmd.last <= 1'b1;
							end
							default: begin
								cmd.op <= OP_DOWN; cmd.first <= 1'b1; cmd.last <= 1'b1;
							end
						endcase
					end else if (!sts.mac_busy && cmd.op == OP_NONE) begin
						wait_q <= 1'b0;
						if (st_q == S_PPHI || st_q == S_PHIP || st_q == S_DOWN) begin
							c_q <= c_q + 1'b1;
							if (c_q == 2'd3) begin
								r_q <= r_q + 1'b1;
								if (r_q == 2'd3) begin
									case (st_q)
										S_PPHI:  st_q <= S_PHIP;
										S_PHIP:  st_q <= S_S;
										default: st_q <= S_COV;
									endcase
								end
							end
						end else begin
							r_q <= r_q + 1'b1;
							if (r_q == 2'd3) begin
								case (st_q)
									S_S:     st_q <= S_ACC;
									S_ACC:   st_q <= S_DEN;
									default: st_q <= S_DOWN;
								endcase
							end
						end
					end
				end
				S_DEN: begin
					cmd.op <= OP_DEN;
					st_q <= S_GAIN;
				end
				S_GAIN, S_COV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
						cmd.op <= (st_q == S_GAIN) ? OP_GAIN : OP_COV;
						cmd.r <= r_q;
						cmd.c <= c_q;
					end else if (!sts.div_busy && cmd.op == OP_NONE) begin
						wait_q <= 1'b0;
						if (st_q == S_GAIN) begin
							r_q <= r_q + 1'b1;
							if (r_q == 2'd3) st_q <= S_THETA;
						end else begin
							c_q <= c_q + 1'b1;
							if (c_q == 2'd3) begin
								r_q <= r_q + 1'b1;
								if (r_q == 2'd3) st_q <= S_DRAIN;
							end
						end
					end
				end
				S_DRAIN: if (out_free) begin
					cmd.op <= OP_OUT;
					st_q <= S_OUT;
				end
				S_OUT: begin
					out_load <= 1'b1;
					busy <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
